[design/pcg32_bounded_integer_generator_defines.svh]
// Assertion macros for the bounded PCG32 integer generator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef PCG32_BOUNDED_INTEGER_GENERATOR_DEFINES_SVH
`define PCG32_BOUNDED_INTEGER_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define PCG_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcg32 same-cycle check failed");
`define PCG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcg32 next-cycle check failed");
`else
`define PCG_ASSERT_SAME(label, clk, rst, ante, cons)
`define PCG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[design/pcgbig_pkg.sv]
// Package for the bounded PCG32 integer generator: widths, generator constants
// and the XSH-RR output function. No dependencies.
`default_nettype none

package pcgbig_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned HALF_W = 32;
  localparam int unsigned CFG_ADDR_W = 2;

  // Linear congruential multiplier.
  localparam logic [WORD_W-1:0] PCG_MULT = 64'd6364136223846793005;

  // Seeding with seed 0 and stream 0 leaves inc = 1 and state = MULT + 1.
  localparam logic [WORD_W-1:0] RESET_INC   = 64'd1;
  localparam logic [WORD_W-1:0] RESET_STATE = 64'd6364136223846793006;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_SEED  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_STREAM = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LOW   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_HIGH  = 2'd3;

  // XSH-RR: xor-shift the old state, keep 32 bits, rotate right by the top five bits.
  function automatic logic [HALF_W-1:0] xsh_rr(input logic [WORD_W-1:0] old);
    logic [WORD_W-1:0]   xs;
    logic [HALF_W-1:0]   mixed;
    logic [4:0]          rot;
    logic [2*HALF_W-1:0] dbl;
    xs    = ((old >> 18) ^ old) >> 27;
    mixed = xs[HALF_W-1:0];
    rot   = old[63:59];
    dbl   = {mixed, mixed} >> rot;
    return dbl[HALF_W-1:0];
  endfunction

endpackage

`default_nettype wire

[design/pcg32_bounded_integer_generator.sv]
// Top level of the bounded PCG32 integer generator: sequencer, shared 32x32
// multiplier, bit-serial remainder unit and output register.
// Depends on pcgbig_pkg and pcg32_bounded_integer_generator_defines.svh.
`default_nettype none

`include "pcg32_bounded_integer_generator_defines.svh"

// Each input word asks for one unbiased integer in [range_low, range_high).
// The generator is a 64-bit PCG32 state stepped by one shared 32x32 multiplier
// through the states S_MUL0, S_MUL1 and S_MUL2, and the 64-bit draw is reduced
// by a restoring remainder unit that retires one dividend bit per cycle. A normal
// request is accepted, runs two generator steps and the remainder loop, and then
// S_CHK and S_FIN check the draw and form the value. A restart adds one more
// generator step. A rejected draw costs two more generator steps and another pass
// of the remainder loop and the check. An empty or inverted range is answered
// through S_ERR with the error flag set and value zero, and leaves the generator alone.
// The block takes one request at a time; s_tready is high only while idle, and
// a finished result waits in the output register if the sink stalls.
// Configuration registers are written through cfg_we/cfg_addr/cfg_data and must
// only be changed while the block is idle. Reset seeds the generator as if seed
// and stream were both zero; there is no clearing pass.
module pcg32_bounded_integer_generator (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Input stream; tdata fields from bit 0: restart, then zero fill.
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [7:0]                        s_tdata,
  // Output stream; tdata fields from bit 0: value.
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [pcgbig_pkg::WORD_W-1:0]          m_tdata,
  // tuser fields from bit 0: error.
  output logic [0:0]                             m_tuser,
  // Configuration write port.
  input  wire logic                              cfg_we,
  input  wire logic [pcgbig_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [pcgbig_pkg::WORD_W-1:0]     cfg_data
);
  import pcgbig_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL0 = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_CHK  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_ERR  = 3'd7;

  // What the word of the current generator step is used for.
  localparam logic [1:0] K_SEED = 2'd0;
  localparam logic [1:0] K_HI   = 2'd1;
  localparam logic [1:0] K_LO   = 2'd2;

  localparam int unsigned CNT_W = $clog2(WORD_W);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(WORD_W - 1);

  // Configuration registers.
  logic [WORD_W-1:0] seed_value;
  logic [WORD_W-1:0] stream_id;
  logic [WORD_W-1:0] range_low;
  logic [WORD_W-1:0] range_high;

  // Generator and datapath registers.
  logic [WORD_W-1:0] gstate;
  logic [WORD_W-1:0] inc;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] span;
  logic [WORD_W-1:0] draw;
  logic [WORD_W-1:0] dvd;
  logic [WORD_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;
  logic [1:0]        kind;
  logic [2:0]        state;

  logic              in_acc;
  logic              out_free;
  logic              out_load;
  logic [HALF_W-1:0] mul_a;
  logic [HALF_W-1:0] mul_b;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] add_a;
  logic [WORD_W-1:0] add_b;
  logic [WORD_W-1:0] sum;
  logic [HALF_W-1:0] word;
  logic [WORD_W-1:0] inc_new;
  logic [WORD_W:0]   rem_sh;
  logic [WORD_W:0]   rem_diff;

  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign inc_new  = {stream_id[WORD_W-2:0], 1'b1};
  assign word     = xsh_rr(gstate);

  // A new result word enters the output register this cycle.
  assign out_load = out_free && ((state == S_ERR) || ((state == S_FIN) && (draw <= ~span)));

  // Shared multiplier: the three partial products that reach the low 64 bits
  // of state * MULT, one per cycle.
  always_comb begin
    unique case (state)
      S_MUL1: begin
        mul_a = gstate[HALF_W-1:0];
        mul_b = PCG_MULT[WORD_W-1:HALF_W];
      end
      S_MUL2: begin
        mul_a = gstate[WORD_W-1:HALF_W];
        mul_b = PCG_MULT[HALF_W-1:0];
      end
      default: begin
        mul_a = gstate[HALF_W-1:0];
        mul_b = PCG_MULT[HALF_W-1:0];
      end
    endcase
  end

  assign prod = WORD_W'(mul_a) * WORD_W'(mul_b);

  // One adder: the increment joins in the first cycle, the cross products after.
  always_comb begin
    if (state == S_MUL0) begin
      add_a = prod;
      add_b = inc;
    end else begin
      add_a = acc;
      add_b = {prod[HALF_W-1:0], {HALF_W{1'b0}}};
    end
  end

  assign sum = add_a + add_b;

  // Restoring remainder step.
  assign rem_sh   = {rem, dvd[WORD_W-1]};
  assign rem_diff = rem_sh - {1'b0, span};

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= '0;
      stream_id  <= '0;
      range_low  <= '0;
      range_high <= WORD_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SEED:   seed_value <= cfg_data;
        REG_STREAM: stream_id  <= cfg_data;
        REG_LOW:    range_low  <= cfg_data;
        REG_HIGH:   range_high <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      kind     <= K_HI;
      cnt      <= '0;
      gstate   <= RESET_STATE;
      inc      <= RESET_INC;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            span <= range_high - range_low;
            if (range_high <= range_low) begin
              state <= S_ERR;
            end else if (s_tdata[0]) begin
              // Seeding: state 0 steps to inc, then the seed is added.
              inc    <= inc_new;
              gstate <= inc_new + seed_value;
              kind   <= K_SEED;
              state  <= S_MUL0;
            end else begin
              kind  <= K_HI;
              state <= S_MUL0;
            end
          end
        end
        S_MUL0: begin
          acc   <= sum;
          state <= S_MUL1;
        end
        S_MUL1: begin
          acc   <= sum;
          state <= S_MUL2;
        end
        S_MUL2: begin
          gstate <= sum;
          unique case (kind)
            K_SEED: begin
              kind  <= K_HI;
              state <= S_MUL0;
            end
            K_HI: begin
              draw[WORD_W-1:HALF_W] <= word;
              kind  <= K_LO;
              state <= S_MUL0;
            end
            default: begin
              draw[HALF_W-1:0] <= word;
              dvd   <= {draw[WORD_W-1:HALF_W], word};
              rem   <= '0;
              cnt   <= '0;
              state <= S_DIV;
            end
          endcase
        end
        S_DIV: begin
          rem <= rem_diff[WORD_W] ? rem_sh[WORD_W-1:0] : rem_diff[WORD_W-1:0];
          dvd <= {dvd[WORD_W-2:0], 1'b0};
          cnt <= cnt + CNT_W'(1);
          if (cnt == DIV_LAST) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          // Draw minus remainder is the multiple of the span below the draw.
          draw  <= draw - rem;
          state <= S_FIN;
        end
        S_FIN: begin
          // Accept only if the next multiple of the span still fits in 64 bits.
          if (draw > ~span) begin
            kind  <= K_HI;
            state <= S_MUL0;
          end else if (out_free) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= range_low + rem;
            m_tuser[0] <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= '0;
            m_tuser[0] <= 1'b1;
            state      <= S_IDLE;
          end
        end
      endcase
    end
  end

  // An error word always carries a zero value.
  `PCG_ASSERT_SAME(a_err_zero, clk, rst, m_tvalid && m_tuser[0], m_tdata == '0)
  // The partial remainder never reaches the span.
  `PCG_ASSERT_SAME(a_rem_below_span, clk, rst, state == S_CHK, rem < span)
  // The generator state moves only at the end of a step or when seeding starts.
  `PCG_ASSERT_NEXT(a_state_hold, clk, rst, (state != S_MUL2) && !in_acc, $stable(gstate))
  // A generator step ends either in another step or in the remainder loop.
  `PCG_ASSERT_NEXT(a_step_next, clk, rst, state == S_MUL2,
                   (state == S_MUL0) || (state == S_DIV))

endmodule

`default_nettype wire

[dv/tb_pcg32_bounded_integer_generator.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the bounded PCG32 integer generator: a scoreboard class predicts
// every draw and checks each output word. Needs only pcgbig_pkg and the generator RTL.

typedef struct packed {
  logic [63:0] value;
  logic        error;
} draw_result_t;

// Holds a private copy of the generator state and the four registers, predicts the
// result of every accepted request and checks the words that come out.
class pcg_scoreboard;
  logic [63:0]  seed_r, stream_r, low_r, high_r;
  logic [63:0]  lcg_state, lcg_inc;
  draw_result_t pending_draws[$];
  int unsigned  errors;

  function new();
    seed_r   = '0;
    stream_r = '0;
    low_r    = '0;
    high_r   = 64'd1;
    errors   = 0;
    reseed();
  endfunction

  // One generator step: permuted output of the old state, then the LCG advance.
  function logic [31:0] next_word();
    logic [63:0] old, shifted;
    logic [31:0] mixed;
    int unsigned rot;
    old       = lcg_state;
    shifted   = ((old >> 18) ^ old) >> 27;
    mixed     = shifted[31:0];
    rot       = 32'(old[63:59]);
    lcg_state = old * pcgbig_pkg::PCG_MULT + lcg_inc;
    return (mixed >> rot) | (mixed << ((32 - rot) & 31));
  endfunction

  function void reseed();
    lcg_state = '0;
    lcg_inc   = {stream_r[62:0], 1'b1};
    void'(next_word());
    lcg_state = lcg_state + seed_r;
    void'(next_word());
  endfunction

  function void write_reg(logic [pcgbig_pkg::CFG_ADDR_W-1:0] addr, logic [63:0] data);
    case (addr)
      pcgbig_pkg::REG_SEED:   seed_r   = data;
      pcgbig_pkg::REG_STREAM: stream_r = data;
      pcgbig_pkg::REG_LOW:    low_r    = data;
      pcgbig_pkg::REG_HIGH:   high_r   = data;
      default: ;
    endcase
  endfunction

  function void take_request(bit restart);
    logic [63:0]  span, lim, draw, ones;
    draw_result_t r;
    ones = '1;
    if (high_r <= low_r) begin
      // Empty or inverted range: flag it and leave the generator untouched.
      r.value = '0;
      r.error = 1'b1;
    end else begin
      if (restart) reseed();
      span = high_r - low_r;
      lim  = ones - (ones % span);
      do begin
        draw[63:32] = next_word();
        draw[31:0]  = next_word();
      end while (draw >= lim);
      r.value = low_r + draw % span;
      r.error = 1'b0;
    end
    pending_draws.push_back(r);
  endfunction

  function void check_result(logic [63:0] value, logic error);
    draw_result_t e;
    if (pending_draws.size() == 0) begin
      $error("unexpected result word: value %h error %b", value, error);
      errors++;
      return;
    end
    e = pending_draws.pop_front();
    if (value !== e.value) begin
      $error("value mismatch: expected %h actual %h", e.value, value);
      errors++;
    end
    if (error !== e.error) begin
      $error("error mismatch: expected %b actual %b", e.error, error);
      errors++;
    end
  endfunction

  function int pending();
    return pending_draws.size();
  endfunction
endclass

module tb_pcg32_bounded_integer_generator;
  import pcgbig_pkg::*;

  // Cycles without any accepted word before the run is declared hung. The slowest
  // correct stretch is the long sink hold-off plus a request and a few rejection
  // rounds, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_OFF_CYCLES = 3000;
  localparam int RANDOM_PHASES = 12;
  localparam int WORDS_PER_PHASE = 50;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = '0;   // bit 0: restart, bits 7:1 zero fill
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [WORD_W-1:0] m_tdata;        // bits 63:0: value
  logic [0:0]        m_tuser;        // bit 0: error
  logic              cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [WORD_W-1:0] cfg_data = '0;

  pcg_scoreboard sb = new();

  // When set, the sink stops taking results for a long stretch so that the block
  // fills up and holds its input ready low. In calm phases neither side idles.
  bit hold_off_req = 1'b0;
  bit calm = 1'b0;
  int idle_cycles = 0;

  pcg32_bounded_integer_generator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Both handshakes are sampled here, at the edge, with the values that held just
  // before it; every accepted request word is handed to the predictor and every
  // accepted result word is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.take_request(s_tdata[0]);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
    end
  end

  // The watchdog only counts edges at which neither side moved a word.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // The sink: runs of ready and short stalls, now and then a long stall, and one
  // long hold-off when the stimulus asks for it. Each branch makes one assignment
  // to m_tready and then waits for the clock before the next pass.
  initial begin : sink
    int r;
    forever begin
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (calm) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          m_tready <= 1'b1;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end else if (r < 95) begin
          m_tready <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end else begin
          m_tready <= 1'b0;
          repeat ($urandom_range(20, 150)) @(posedge clk);
        end
      end
    end
  end

  // Gap before the next request word: mostly none or short, sometimes long.
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(20, 200);
  endfunction

  function logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Offers one request word, after an optional gap, and returns at the edge that
  // accepted it. Valid stays high between back-to-back words.
  task send_word(bit restart, int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, restart};
    do @(posedge clk); while (!s_tready);
  endtask

  // Sends a short directed list of restart bits, lowest bit first.
  task send_list(bit [7:0] restarts, int n);
    for (int i = 0; i < n; i++) send_word(restarts[i], pick_gap());
    s_tvalid <= 1'b0;
  endtask

  // Waits until every predicted result has been taken. The first edge makes sure
  // that the word accepted at the last edge has already been noted. Every request
  // yields a result, so once nothing is pending the block is idle again.
  task wait_idle();
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task write_one(logic [CFG_ADDR_W-1:0] addr, logic [63:0] data);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    sb.write_reg(addr, data);
    @(posedge clk);
  endtask

  // Writes the registers selected by the mask, only once the block has gone idle.
  task program_regs(bit [3:0] mask, logic [63:0] seed, logic [63:0] stream,
                    logic [63:0] lo, logic [63:0] hi);
    wait_idle();
    if (mask[REG_SEED])   write_one(REG_SEED, seed);
    if (mask[REG_STREAM]) write_one(REG_STREAM, stream);
    if (mask[REG_LOW])    write_one(REG_LOW, lo);
    if (mask[REG_HIGH])   write_one(REG_HIGH, hi);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [63:0] ones, lo, hi, span;
    int          r, restart_pct;
    ones = '1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values give a range of one starting at zero, with and without restart.
    send_list(8'b0000_0010, 2);

    // Equal and inverted bounds: the error flag, and a restart that must be ignored.
    program_regs(4'b1100, '0, '0, 64'd5, 64'd5);
    send_list(8'b0000_0001, 2);
    program_regs(4'b1100, '0, '0, ones, '0);
    send_list(8'b0000_0001, 1);

    // All-ones seed and stream over the widest span; only the all-ones draw is rejected.
    program_regs(4'b1111, ones, ones, '0, ones);
    send_list(8'b0000_0001, 3);

    // Stream with only its top bit set, which is lost when the increment is formed.
    program_regs(4'b0011, '0, 64'h8000_0000_0000_0000, '0, '0);
    send_list(8'b0000_0001, 2);

    // Range of one at the very top of the value space.
    program_regs(4'b1100, '0, '0, ones - 64'd1, ones);
    send_list(8'b0000_0010, 2);

    // A span just above half the space, where about half of all draws are rejected.
    program_regs(4'b1100, '0, '0, '0, 64'h8000_0000_0000_0001);
    send_list(8'b0000_0000, 4);

    // A new stream only counts from the next restart.
    program_regs(4'b1110, '0, 64'd12345, 64'd100, 64'd103);
    send_list(8'b0000_0010, 3);

    // Random phases: fresh registers between phases, then a burst of requests.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // Empty or inverted range.
        lo = rand64();
        hi = ($urandom_range(0, 1) != 0) ? lo : lo - {32'd0, $urandom_range(1, 1000)};
        if (hi > lo) hi = lo;
      end else if (r < 30) begin
        span = 64'($urandom_range(1, 16));
        lo = ($urandom_range(0, 3) == 0) ? '0 : rand64();
        hi = lo + span;
        if (hi < lo) begin
          lo = ones - span;
          hi = ones;
        end
      end else if (r < 55) begin
        lo = rand64();
        hi = rand64();
        if (hi < lo) {lo, hi} = {hi, lo};
        if (hi == lo) hi = lo + 64'd1;
        if (hi == '0) begin
          lo = '0;
          hi = 64'd1;
        end
      end else if (r < 70) begin
        lo = {32'd0, $urandom_range(0, 255)};
        hi = lo + 64'h8000_0000_0000_0000 + $urandom_range(0, 3);
      end else if (r < 80) begin
        lo = '0;
        hi = ones;
      end else begin
        lo = '0;
        hi = {32'd0, $urandom()} + 64'd2;
      end
      program_regs(4'(($urandom_range(0, 3) << 2) | 4'b1100 | $urandom_range(0, 3)),
                   ($urandom_range(0, 7) == 0) ? ones : rand64(),
                   ($urandom_range(0, 7) == 0) ? ones : rand64(), lo, hi);

      calm = (phase % 4 == 0);
      if (phase == 5) hold_off_req = 1'b1;
      restart_pct = $urandom_range(0, 30);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        send_word($urandom_range(0, 99) < restart_pct, pick_gap());
      end
      s_tvalid <= 1'b0;
    end

    calm = 1'b0;
    wait_idle();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
